// File: hw/rtl/sprite_column_occlusion_clipper_assert.svh
// Assertion macros used by the sprite column occlusion clipper RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SPRITE_COLUMN_OCCLUSION_CLIPPER_ASSERT_SVH
`define SPRITE_COLUMN_OCCLUSION_CLIPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define SCOC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("scoc assertion failed");
`define SCOC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("scoc assertion failed");
`else
`define SCOC_ASSERT(label, clk, rst, prop)
`define SCOC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: hw/rtl/scoc_pkg.sv
// Shared constants, state and command types of the sprite column occlusion clipper.
// No dependencies; imported by every module of the block but scoc_ram.
`default_nettype none
package scoc_pkg;

   localparam int SCREEN_COLUMNS = 320;
   localparam int COL_W          = $clog2(SCREEN_COLUMNS);

   localparam int IDX_W   = 9;
   localparam int DEPTH_W = 20;
   localparam int POS_W   = 12;
   localparam int SIZE_W  = 11;
   localparam int TEX_W   = 8;
   localparam int PROD_W  = COL_W + TEX_W;
   // Signed width that holds left + width and the last column index.
   localparam int EXT_W   = 14;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_CLIP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RD_R,
      ST_EDGE,
      ST_SCAN,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      ADDR_LB,
      ADDR_RB,
      ADDR_SCAN
   } addr_sel_type;

   typedef enum logic [1:0] {
      OUT_HIDE,
      OUT_WHOLE,
      OUT_CLIP_LEFT,
      OUT_CLIP_RIGHT
   } out_kind_type;

   typedef struct packed {
      logic         wr_col;
      logic         load;
      addr_sel_type addr_sel;
      logic         cap_lnear;
      logic         scan_init;
      logic         scan_back;
      logic         scan_step;
      logic         cap_hit;
      logic         mul;
      logic         div_start;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic lnear;
      logic rnear;
      logic hit;
      logic exhausted;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/sprite_column_occlusion_clipper.sv
// A write beat gives no result. A clip beat goes from the check straight to the result for an
// empty span, and from the edge test when the sprite is hidden or whole. Otherwise a march
// reads the visited columns one by one on the single depth RAM read port; when no farther
// column turns up the sprite stays whole, else a trim runs the multiply and then the divide.
// One item at a time: a new request is taken only in idle, after the last result is loaded.
// Reset (synchronous, active high) clears the controller, the march flags and the
// divider; the depth memory is not cleared and holds nothing until written.
`default_nettype none
module sprite_column_occlusion_clipper (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // func
   input  wire logic                            req_tuser,
   // column_index, column_depth, sprite_left, sprite_top, sprite_width, sprite_height,
   // sprite_distance, texture_size, zero pad
   input  wire logic [scoc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // visible
   output logic                                 rsp_tuser,
   // dst_left, dst_top, dst_width, dst_height, src_left, src_width, src_height, zero pad
   output logic      [scoc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import scoc_pkg::*;

   cmd_type    cmd;
   status_type status;

   scoc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   scoc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: hw/rtl/scoc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/scoc_div.sv
// Restoring divider, one quotient bit per cycle, for the texture offset.
// Depends on scoc_pkg.
`default_nettype none
module scoc_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [scoc_pkg::PROD_W-1:0] dividend,
   input  wire logic [scoc_pkg::SIZE_W-1:0] divisor,
   output logic                             done,
   output logic      [scoc_pkg::PROD_W-1:0] quotient
);
   import scoc_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] div_ff, div_in;
   logic [SIZE_W:0]   trial;
   logic [SIZE_W:0]   diff;
   logic              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      diff    = trial - {1'b0, div_ff};
      ge      = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PROD_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: hw/rtl/scoc_datapath.sv
// Datapath: depth memory, span clamp, column march, multiply, divide and result register.
// Depends on scoc_pkg, scoc_ram and scoc_div; driven by scoc_ctrl commands.
`default_nettype none
module scoc_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [scoc_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire scoc_pkg::cmd_type               cmd,
   output scoc_pkg::status_type                 status,
   output logic      [scoc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                 rsp_tuser
);
   import scoc_pkg::*;

   localparam logic signed [EXT_W-1:0] LAST_COL = EXT_W'(SCREEN_COLUMNS - 1);

   // Input fields as packed in req_tdata.
   logic        [IDX_W-1:0]   in_index;
   logic        [DEPTH_W-1:0] in_depth;
   logic signed [POS_W-1:0]   in_left;
   logic        [POS_W-1:0]   in_top;
   logic        [SIZE_W-1:0]  in_width;
   logic        [SIZE_W-1:0]  in_height;
   logic        [DEPTH_W-1:0] in_dist;
   logic        [TEX_W-1:0]   in_tex;

   assign in_index  = req_tdata[8:0];
   assign in_depth  = req_tdata[28:9];
   assign in_left   = signed'(req_tdata[40:29]);
   assign in_top    = req_tdata[52:41];
   assign in_width  = req_tdata[63:53];
   assign in_height = req_tdata[74:64];
   assign in_dist   = req_tdata[94:75];
   assign in_tex    = req_tdata[102:95];

   logic signed [EXT_W-1:0] left_x, sum_x, lb_x, rb_x;
   logic                    span_empty;

   always_comb begin
      left_x     = EXT_W'(in_left);
      sum_x      = left_x + signed'(EXT_W'(in_width));
      lb_x       = left_x[EXT_W-1] ? '0 : left_x;
      rb_x       = (sum_x > LAST_COL) ? LAST_COL : sum_x;
      span_empty = (in_width == '0) || (lb_x > rb_x);
   end

   // Item registers.
   logic [POS_W-1:0]   left_ff, top_ff;
   logic [SIZE_W-1:0]  w_ff, h_ff, lb_ff;
   logic [COL_W-1:0]   rb_ff;
   logic [DEPTH_W-1:0] dist_ff;
   logic [TEX_W-1:0]   s_ff;
   logic               empty_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         left_ff  <= in_left;
         top_ff   <= in_top;
         w_ff     <= in_width;
         h_ff     <= in_height;
         lb_ff    <= SIZE_W'(lb_x);
         rb_ff    <= COL_W'(rb_x);
         dist_ff  <= in_dist;
         s_ff     <= in_tex;
         empty_ff <= span_empty;
      end
   end

   // Depth memory.
   logic               wr_en;
   logic [COL_W-1:0]   rd_addr;
   logic [DEPTH_W-1:0] rd_data;
   logic [COL_W-1:0]   ptr_ff, ptr_in;

   assign wr_en = cmd.wr_col && (int'(in_index) < SCREEN_COLUMNS);

   always_comb begin
      case (cmd.addr_sel)
         ADDR_LB:   rd_addr = COL_W'(lb_ff);
         ADDR_RB:   rd_addr = rb_ff;
         ADDR_SCAN: rd_addr = ptr_ff;
         default:   rd_addr = ptr_ff;
      endcase
   end

   scoc_ram #(
      .WIDTH (DEPTH_W),
      .DEPTH (SCREEN_COLUMNS)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (COL_W'(in_index)),
      .wr_data (in_depth),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Column march: the pointer issues reads, the compare stage sees the data in the next cycle.
   logic             lnear_ff, lnear_in;
   logic [COL_W-1:0] end_ff, end_in;
   logic             back_ff, back_in;
   logic             issued_ff, issued_in;
   logic             cmp_v_ff, cmp_v_in;
   logic [COL_W-1:0] cmp_x_ff, cmp_x_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic [COL_W-1:0] k_ff, k_in;
   logic             nearer, farther;

   always_comb begin
      nearer    = rd_data < dist_ff;
      farther   = rd_data > dist_ff;
      lnear_in  = cmd.cap_lnear ? nearer : lnear_ff;
      ptr_in    = ptr_ff;
      end_in    = end_ff;
      back_in   = back_ff;
      issued_in = issued_ff;
      cmp_v_in  = 1'b0;
      cmp_x_in  = ptr_ff;
      if (cmd.scan_init) begin
         ptr_in    = cmd.scan_back ? rb_ff : COL_W'(lb_ff);
         end_in    = cmd.scan_back ? COL_W'(lb_ff) : rb_ff;
         back_in   = cmd.scan_back;
         issued_in = 1'b0;
      end else if (cmd.scan_step && !issued_ff) begin
         cmp_v_in = 1'b1;
         if (ptr_ff == end_ff) begin
            issued_in = 1'b1;
         end else begin
            ptr_in = back_ff ? ptr_ff - COL_W'(1) : ptr_ff + COL_W'(1);
         end
      end
      x_in = cmd.cap_hit ? cmp_x_ff : x_ff;
      k_in = cmd.cap_hit ? cmp_x_ff - COL_W'(lb_ff) : k_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issued_ff <= 1'b1;
         cmp_v_ff  <= 1'b0;
      end else begin
         issued_ff <= issued_in;
         cmp_v_ff  <= cmp_v_in;
      end
      lnear_ff <= lnear_in;
      ptr_ff   <= ptr_in;
      end_ff   <= end_in;
      back_ff  <= back_in;
      cmp_x_ff <= cmp_x_in;
      x_ff     <= x_in;
      k_ff     <= k_in;
   end

   // Texture offset: floor(k * s / w).
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] quotient;
   logic              div_done;
   logic [TEX_W-1:0]  f;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(k_ff) * PROD_W'(s_ff);
      end
   end

   scoc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (w_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign f = quotient[TEX_W-1:0];

   // Result register.
   logic              vis_ff, vis_in;
   logic [POS_W-1:0]  dl_ff, dl_in, dt_ff, dt_in;
   logic [SIZE_W-1:0] dw_ff, dw_in, dh_ff, dh_in;
   logic [TEX_W-1:0]  sl_ff, sl_in, sw_ff, sw_in, sh_ff, sh_in;

   always_comb begin
      vis_in = 1'b0;
      dl_in  = '0;
      dt_in  = '0;
      dw_in  = '0;
      dh_in  = '0;
      sl_in  = '0;
      sw_in  = '0;
      sh_in  = '0;
      case (cmd.out_kind)
         OUT_HIDE: begin
            vis_in = 1'b0;
         end
         OUT_WHOLE: begin
            vis_in = 1'b1;
            dl_in  = left_ff;
            dt_in  = top_ff;
            dw_in  = w_ff;
            dh_in  = h_ff;
            sw_in  = s_ff;
            sh_in  = s_ff;
         end
         OUT_CLIP_LEFT: begin
            vis_in = 1'b1;
            dl_in  = POS_W'(x_ff);
            dt_in  = top_ff;
            dw_in  = w_ff - SIZE_W'(k_ff);
            dh_in  = h_ff;
            sl_in  = f;
            sw_in  = s_ff - f;
            sh_in  = s_ff;
         end
         OUT_CLIP_RIGHT: begin
            vis_in = 1'b1;
            dl_in  = POS_W'(lb_ff);
            dt_in  = top_ff;
            dw_in  = SIZE_W'(k_ff);
            dh_in  = h_ff;
            sw_in  = f;
            sh_in  = s_ff;
         end
         default: begin
            vis_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         vis_ff <= vis_in;
         dl_ff  <= dl_in;
         dt_ff  <= dt_in;
         dw_ff  <= dw_in;
         dh_ff  <= dh_in;
         sl_ff  <= sl_in;
         sw_ff  <= sw_in;
         sh_ff  <= sh_in;
      end
   end

   assign rsp_tuser = vis_ff;
   assign rsp_tdata = {2'b00, sh_ff, sw_ff, sl_ff, dh_ff, dw_ff, dt_ff, dl_ff};

   always_comb begin
      status.empty     = empty_ff;
      status.lnear     = lnear_ff;
      status.rnear     = nearer;
      status.hit       = cmp_v_ff && farther;
      status.exhausted = issued_ff && !cmp_v_ff;
      status.div_done  = div_done;
   end

endmodule
`default_nettype wire

// File: hw/rtl/scoc_ctrl.sv
// Controller state machine: sequences edge reads, the column march, the multiply and divide, and the result.
// Depends on scoc_pkg and the assertion macro header.
`default_nettype none
`include "sprite_column_occlusion_clipper_assert.svh"
module scoc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tuser,
   output logic                      req_tready,
   input  wire logic                 rsp_tready,
   output logic                      rsp_tvalid,
   output scoc_pkg::cmd_type         cmd,
   input  wire scoc_pkg::status_type status
);
   import scoc_pkg::*;

   state_type    state_ff, state_in;
   out_kind_type kind_ff, kind_in;
   logic         rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= OUT_HIDE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == FUNC_CLIP) begin
                  cmd.load = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  cmd.wr_col = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            if (status.empty) begin
               kind_in  = OUT_HIDE;
               state_in = ST_FINISH;
            end else begin
               cmd.addr_sel = ADDR_LB;
               state_in     = ST_RD_R;
            end
         end
         ST_RD_R: begin
            cmd.addr_sel  = ADDR_RB;
            cmd.cap_lnear = 1'b1;
            state_in      = ST_EDGE;
         end
         ST_EDGE: begin
            if (status.lnear && status.rnear) begin
               kind_in  = OUT_HIDE;
               state_in = ST_FINISH;
            end else if (!status.lnear && !status.rnear) begin
               kind_in  = OUT_WHOLE;
               state_in = ST_FINISH;
            end else begin
               cmd.scan_init = 1'b1;
               cmd.scan_back = status.rnear;
               kind_in       = status.lnear ? OUT_CLIP_LEFT : OUT_CLIP_RIGHT;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.addr_sel  = ADDR_SCAN;
            cmd.scan_step = 1'b1;
            if (status.hit) begin
               cmd.cap_hit = 1'b1;
               state_in    = ST_MUL;
            end else if (status.exhausted) begin
               // No farther column on the whole span: the sprite stays whole.
               kind_in  = OUT_WHOLE;
               state_in = ST_FINISH;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = kind_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `SCOC_ASSERT(a_out_slot_free, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
   `SCOC_ASSERT(a_div_done_in_wait, clock, reset, status.div_done |-> (state_ff == ST_DIV_WAIT))
   `SCOC_ASSERT(a_hit_not_exhausted, clock, reset, !(status.hit && status.exhausted))
   `SCOC_ASSERT_NEXT(a_hit_to_mul, clock, reset, (state_ff == ST_SCAN) && status.hit, state_ff == ST_MUL)

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the sprite column occlusion clipper: a queue-fed driver, an
// in-order result monitor and a behavioral predictor of the column depth store.
// Depends on scoc_pkg and the sprite_column_occlusion_clipper RTL only.
`timescale 1ns / 100ps

module tb_top;

   import scoc_pkg::*;

   localparam int CYCLE_LIMIT    = 1500000;
   localparam int RANDOM_ITEMS   = 110;
   localparam int HOLD_CYCLES    = 1500;
   localparam int HOLD_AT_RESULT = 20;
   localparam int DEPTH_MAX      = 1048575;

   typedef struct packed {
      logic               func;
      logic [8:0]         col_idx;
      logic [19:0]        col_depth;
      logic signed [11:0] spr_left;
      logic signed [11:0] spr_top;
      logic [10:0]        spr_width;
      logic [10:0]        spr_height;
      logic [19:0]        spr_dist;
      logic [7:0]         tex_size;
   } sprite_req_type;

   typedef struct packed {
      logic        visible;
      logic [11:0] dst_left;
      logic [11:0] dst_top;
      logic [10:0] dst_width;
      logic [10:0] dst_height;
      logic [7:0]  src_left;
      logic [7:0]  src_width;
      logic [7:0]  src_height;
   } clip_rect_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sprite_column_occlusion_clipper DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   sprite_req_type pending_req_q[$];
   clip_rect_type  clip_expect_q[$];
   logic [19:0]    wall_depth_mirror [SCREEN_COLUMNS];

   sprite_req_type on_bus;
   int             beats_in     = 0;
   int             writes_in    = 0;
   int             clips_in     = 0;
   int             hidden_cnt   = 0;
   int             trimmed_cnt  = 0;
   int             results_seen = 0;
   int             failures     = 0;
   int             hold_left    = 0;
   bit             hold_done    = 0;
   int             cycle_count  = 0;

   // Clip prediction against the mirrored column depths.
   function automatic clip_rect_type predict_clip(sprite_req_type r);
      int            lft, w, s, lb, rb, x, k, f, hit;
      bit            lnear, rnear;
      clip_rect_type o;
      o   = '0;
      lft = r.spr_left;
      w   = r.spr_width;
      s   = r.tex_size;
      lb  = (lft > 0) ? lft : 0;
      rb  = lft + w;
      if (rb > SCREEN_COLUMNS - 1) rb = SCREEN_COLUMNS - 1;
      if (w == 0 || lb > rb) return o;
      lnear = wall_depth_mirror[lb] < r.spr_dist;
      rnear = wall_depth_mirror[rb] < r.spr_dist;
      if (lnear && rnear) return o;
      o.visible    = 1'b1;
      o.dst_left   = r.spr_left;
      o.dst_top    = r.spr_top;
      o.dst_width  = r.spr_width;
      o.dst_height = r.spr_height;
      o.src_left   = '0;
      o.src_width  = r.tex_size;
      o.src_height = r.tex_size;
      hit = -1;
      if (lnear) begin
         for (x = lb; x <= rb && hit < 0; x++)
            if (wall_depth_mirror[x] > r.spr_dist) hit = x;
         if (hit >= 0) begin
            k = hit - lb;
            f = (k * s) / w;
            o.dst_left  = 12'(hit);
            o.dst_width = 11'(w - k);
            o.src_left  = 8'(f);
            o.src_width = 8'(s - f);
         end
      end else if (rnear) begin
         for (x = rb; x >= lb && hit < 0; x--)
            if (wall_depth_mirror[x] > r.spr_dist) hit = x;
         if (hit >= 0) begin
            k = hit - lb;
            f = (k * s) / w;
            o.dst_left  = 12'(lb);
            o.dst_width = 11'(k);
            o.src_width = 8'(f);
         end
      end
      return o;
   endfunction

   function automatic void queue_req(sprite_req_type r);
      pending_req_q = {pending_req_q, r};
   endfunction

   // Fields that an item does not use carry random noise.
   function automatic sprite_req_type write_item(int idx, int depth);
      sprite_req_type r;
      r           = sprite_req_type'(REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
      r.func      = FUNC_WRITE;
      r.col_idx   = 9'(idx);
      r.col_depth = 20'(depth);
      return r;
   endfunction

   function automatic sprite_req_type clip_item(int lft, int top, int w, int h, int distance,
                                                int tex);
      sprite_req_type r;
      r            = sprite_req_type'(REQ_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
      r.func       = FUNC_CLIP;
      r.spr_left   = 12'(lft);
      r.spr_top    = 12'(top);
      r.spr_width  = 11'(w);
      r.spr_height = 11'(h);
      r.spr_dist   = 20'(distance);
      r.tex_size   = 8'(tex);
      return r;
   endfunction

   function automatic int near_depth(int base);
      int v;
      v = base + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > DEPTH_MAX) v = DEPTH_MAX;
      return v;
   endfunction

   // Driver: a beat moves when valid and ready are both high at the edge.
   always @(posedge clock) begin
      clip_rect_type exp_rect;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            beats_in++;
            if (on_bus.func == FUNC_WRITE) begin
               writes_in++;
               if (on_bus.col_idx < SCREEN_COLUMNS)
                  wall_depth_mirror[on_bus.col_idx] = on_bus.col_depth;
            end else begin
               clips_in++;
               exp_rect = predict_clip(on_bus);
               clip_expect_q = {clip_expect_q, exp_rect};
               if (!exp_rect.visible) hidden_cnt++;
               else if (exp_rect.dst_width != on_bus.spr_width) trimmed_cnt++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (pending_req_q.size() > 0 &&
                ((beats_in >= 360 && beats_in < 420) || $urandom_range(0, 99) >= 26)) begin
               on_bus = pending_req_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.func;
               req_tdata  <= {1'b0, on_bus.tex_size, on_bus.spr_dist, on_bus.spr_height,
                              on_bus.spr_width, on_bus.spr_top, on_bus.spr_left,
                              on_bus.col_depth, on_bus.col_idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result beat in order and drives the result-side stalls.
   always @(posedge clock) begin
      clip_rect_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.visible    = rsp_tuser;
            got.dst_left   = rsp_tdata[11:0];
            got.dst_top    = rsp_tdata[23:12];
            got.dst_width  = rsp_tdata[34:24];
            got.dst_height = rsp_tdata[45:35];
            got.src_left   = rsp_tdata[53:46];
            got.src_width  = rsp_tdata[61:54];
            got.src_height = rsp_tdata[69:62];
            if (clip_expect_q.size() == 0) begin
               $error("result beat with no clip pending: tuser=%0h tdata=%0h",
                      rsp_tuser, rsp_tdata);
               failures++;
            end else begin
               want = clip_expect_q.pop_front();
               if (got.visible !== want.visible) begin
                  $error("visible: expected %0d, got %0d", want.visible, got.visible);
                  failures++;
               end
               if (got.dst_left !== want.dst_left) begin
                  $error("dst_left: expected %0d, got %0d",
                         $signed(want.dst_left), $signed(got.dst_left));
                  failures++;
               end
               if (got.dst_top !== want.dst_top) begin
                  $error("dst_top: expected %0d, got %0d",
                         $signed(want.dst_top), $signed(got.dst_top));
                  failures++;
               end
               if (got.dst_width !== want.dst_width) begin
                  $error("dst_width: expected %0d, got %0d", want.dst_width, got.dst_width);
                  failures++;
               end
               if (got.dst_height !== want.dst_height) begin
                  $error("dst_height: expected %0d, got %0d",
                         want.dst_height, got.dst_height);
                  failures++;
               end
               if (got.src_left !== want.src_left) begin
                  $error("src_left: expected %0d, got %0d", want.src_left, got.src_left);
                  failures++;
               end
               if (got.src_width !== want.src_width) begin
                  $error("src_width: expected %0d, got %0d", want.src_width, got.src_width);
                  failures++;
               end
               if (got.src_height !== want.src_height) begin
                  $error("src_height: expected %0d, got %0d",
                         want.src_height, got.src_height);
                  failures++;
               end
            end
         end
         // One long hold-off lets the block fill up and push back on the request side.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (results_seen == HOLD_AT_RESULT && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (results_seen >= 30 && results_seen < 45) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 26);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** sprite_column_occlusion_clipper: FAILED **");
         $finish;
      end
   end

   initial begin
      int n_random, roll, base, a, n, x, lft, w, spr_dist_v, run_val;
      base = 1000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Every column is written before any clip, so no read hits an unwritten entry.
      for (x = 0; x < SCREEN_COLUMNS; x++)
         queue_req(write_item(x, (x < 100) ? 1000 : (x < 200) ? 3000 : 2000));

      // Left edge nearer: trimmed where the far block begins.
      queue_req(clip_item(50, 5, 100, 40, 2000, 64));
      // Right edge nearer: trimmed at the last far column.
      queue_req(clip_item(150, -20, 100, 33, 2500, 200));
      // Both edges nearer, then neither edge nearer.
      queue_req(clip_item(10, 0, 50, 10, 1500, 16));
      queue_req(clip_item(120, 7, 50, 10, 500, 16));
      // A depth equal to the distance is neither nearer nor farther.
      queue_req(clip_item(10, 0, 50, 10, 1000, 16));
      // Left edge nearer but the march never finds a farther column.
      queue_req(write_item(210, 1500));
      queue_req(clip_item(210, 3, 50, 9, 2000, 77));
      // Empty spans on both sides of the screen, and a zero width.
      queue_req(clip_item(2047, 1, 1, 1, 2000, 1));
      queue_req(clip_item(-2048, 1, 100, 1, 2000, 1));
      queue_req(clip_item(10, 1, 0, 1, 2000, 1));
      // Clamping against the right and left screen edges.
      queue_req(clip_item(300, 0, 2047, 2047, 2500, 255));
      queue_req(clip_item(-50, 0, 100, 20, 1500, 100));
      // Out-of-range column write is dropped; extreme depths and distances.
      queue_req(write_item(511, DEPTH_MAX));
      queue_req(write_item(0, 0));
      queue_req(write_item(SCREEN_COLUMNS - 1, DEPTH_MAX));
      queue_req(clip_item(-10, -2048, 2047, 2047, DEPTH_MAX, 255));
      queue_req(clip_item(0, 2047, 1, 0, 0, 1));
      queue_req(clip_item(-1, 100, 2, 5, 1, 255));

      // The sender pauses here until the block has drained completely.
      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || clip_expect_q.size() != 0);

      n_random = 0;
      while (n_random < RANDOM_ITEMS) begin
         // Each scene clusters depths and distances around one base value.
         if ($urandom_range(0, 19) == 0) begin
            roll = $urandom_range(0, 9);
            base = (roll == 0) ? 1 : (roll == 1) ? DEPTH_MAX - 1
                                                 : $urandom_range(4, DEPTH_MAX - 4);
         end
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            if ($urandom_range(0, 7) == 0) begin
               queue_req(write_item($urandom_range(SCREEN_COLUMNS, 511),
                                    $urandom_range(0, DEPTH_MAX)));
            end else begin
               queue_req(write_item($urandom_range(0, SCREEN_COLUMNS - 1),
                  ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, DEPTH_MAX))
                                               : near_depth(base)));
               n_random++;
            end
         end else if (roll < 30) begin
            a = $urandom_range(0, SCREEN_COLUMNS - 1);
            n = $urandom_range(1, 8);
            run_val = near_depth(base);
            for (x = a; x < a + n && x < SCREEN_COLUMNS; x++) begin
               if ($urandom_range(0, 3) == 0) run_val = near_depth(base);
               queue_req(write_item(x, run_val));
               n_random++;
            end
         end else begin
            roll = $urandom_range(0, 99);
            lft = (roll < 70) ? int'($urandom_range(0, 380)) - 40
                              : int'($urandom_range(0, 4095)) - 2048;
            roll = $urandom_range(0, 99);
            w = (roll < 70) ? $urandom_range(1, 200) :
                (roll < 92) ? $urandom_range(1, 2047) :
                (roll < 96) ? 2047 : 1;
            spr_dist_v = ($urandom_range(0, 99) < 85) ? near_depth(base)
                                                      : int'($urandom_range(0, DEPTH_MAX));
            queue_req(clip_item(lft, $urandom_range(0, 4095), w,
                                $urandom_range(0, 2047), spr_dist_v,
                                $urandom_range(1, 255)));
            n_random++;
         end
      end

      do @(negedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || clip_expect_q.size() != 0);
      repeat (40) @(posedge clock);

      $display("Covered %0d column writes and %0d clips (%0d hidden, %0d trimmed).",
               writes_in, clips_in, hidden_cnt, trimmed_cnt);
      $display("Checked %0d result beats with %0d field mismatches.", results_seen, failures);
      if (failures == 0) begin
         $display("** sprite_column_occlusion_clipper: PASSED **");
      end else begin
         $display("** sprite_column_occlusion_clipper: FAILED **");
      end
      $finish;
   end

endmodule
